[rtl/gradient_noise_2d_top_assert.svh]
// ----------------------------------------------------------------------------
// Gradient noise assertion macros
// Property wrappers for the gradient noise block. Simulation builds get the
// checks. Synthesis builds get empty macros.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_2D_TOP_ASSERT_SVH
`define GRADIENT_NOISE_2D_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define GN2_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gn2 same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define GN2_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gn2 next-cycle check failed");
`else
`define GN2_ASSERT_SAME(lbl, ante, cons)
`define GN2_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/gn2_pkg.sv]
// ----------------------------------------------------------------------------
// Gradient noise package
// Formats, hash constants, pipeline depth and the quarter-wave gradient table
// that are shared by the gradient noise modules.
// ----------------------------------------------------------------------------
package gn2_pkg;

  // Fixed-point formats.
  localparam int ANGLE_BITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int INT_BITS   = 16;
  localparam int XY_W       = 32;
  localparam int OUT_W      = 16;

  // Gradient magnitude (Q1.14, up to 16384), signed gradient, and dot product.
  localparam int QW  = 15;
  localparam int GW  = QW + 1;
  localparam int NW  = 17;
  localparam int QSZ = 1 << (ANGLE_BITS - 2);

  // Rounding constant for a shift by FRAC_BITS.
  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

  // Pipeline depth: the input register through the output register.
  localparam int NSTG = 11;

  // Hash multipliers.
  localparam logic [XY_W-1:0] HASH_K1 = 32'd3284157443;
  localparam logic [XY_W-1:0] HASH_K2 = 32'd1911520717;
  localparam logic [XY_W-1:0] HASH_K3 = 32'd2048419325;

  // Two pi in Q30.
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  typedef logic [XY_W-1:0]           hash_t;
  typedef logic [3:0][XY_W-1:0]      hash4_t;
  typedef logic [FRAC_BITS-1:0]      frac_t;
  typedef logic [1:0][FRAC_BITS-1:0] frac2_t;
  typedef logic [FRAC_BITS:0]        wgt_t;
  typedef logic [1:0][FRAC_BITS:0]   wgt2_t;
  typedef logic [INT_BITS-1:0]       cell_t;
  typedef logic signed [GW-1:0]      grad_t;
  typedef logic [3:0][NW-1:0]        dot4_t;
  typedef logic [NSTG-1:0]           stage_en_t;
  typedef logic [QW-1:0]             qsin_tab_t [QSZ+1];

  // Swap the two 16-bit halves of a word.
  function automatic hash_t rot16(input hash_t v);
    return {v[15:0], v[31:16]};
  endfunction

  // Sine in Q14 of 2*pi*r/2^ANGLE_BITS for r in the first quarter, from a
  // truncated Taylor series in Q30. Used only while building the table.
  function automatic logic [QW-1:0] quarter_sin(input int unsigned r);
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned term;
    longint          sum;
    theta = (64'(r) * TWO_PI_Q30) >> ANGLE_BITS;
    t2    = (theta * theta) >> 30;
    term  = theta;
    sum   = $signed(theta);
    term  = ((term * t2) >> 30) / 6;
    sum   = sum - $signed(term);
    term  = ((term * t2) >> 30) / 20;
    sum   = sum + $signed(term);
    term  = ((term * t2) >> 30) / 42;
    sum   = sum - $signed(term);
    term  = ((term * t2) >> 30) / 72;
    sum   = sum + $signed(term);
    term  = ((term * t2) >> 30) / 110;
    sum   = sum - $signed(term);
    term  = ((term * t2) >> 30) / 156;
    sum   = sum + $signed(term);
    term  = ((term * t2) >> 30) / 210;
    sum   = sum - $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    return QW'(($unsigned(sum) + 64'd32768) >> 16);
  endfunction

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t tab;
    for (int r = 0; r <= QSZ; r++) begin
      tab[r] = quarter_sin(r);
    end
    return tab;
  endfunction

  // Quarter-wave sine magnitudes, angle 0 through pi/2 inclusive.
  localparam qsin_tab_t QSIN_TAB = build_qsin();

  // Signed Q1.14 sine of table angle k, by quarter-wave symmetry.
  function automatic grad_t grad_lut(input logic [ANGLE_BITS-1:0] k);
    logic [1:0]            q;
    logic [ANGLE_BITS-2:0] r;
    grad_t                 m;
    q = k[ANGLE_BITS-1 -: 2];
    r = {1'b0, k[ANGLE_BITS-3:0]};
    if (q[0]) begin
      r = (ANGLE_BITS-1)'(QSZ) - r;
    end
    m = {1'b0, QSIN_TAB[r]};
    return q[1] ? -m : m;
  endfunction

endpackage

[rtl/gradient_noise_2d_top.sv]
// ----------------------------------------------------------------------------
// Two-dimensional gradient noise, top level
// Stream in a point, stream out one interpolated gradient noise sample.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one point per beat: tdata[31:0] is x_pos and
// tdata[63:32] is y_pos, both unsigned Q16.16. The master stream returns
// one beat per point with noise_value, signed Q2.14, in tdata[15:0], in the
// same order as the points arrived.
// The block is an eleven-stage pipeline: input register, three hash
// multiply stages, two weight stages running alongside, gradient lookup,
// offset multiply, dot-product rounding, two blend stages along x and two
// along y, the last of which is the output register. One point per cycle
// is taken for as long as results are taken.
// When the receiver stalls, stages behind the held result keep filling
// until they are full, so empty slots are squeezed out before the slave
// side is held off. Reset clears all valid flags; the datapath needs none.
// ----------------------------------------------------------------------------
`include "gradient_noise_2d_top_assert.svh"

module gradient_noise_2d_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] x_pos, [63:32] y_pos
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] noise_value
);

  localparam int F    = gn2_pkg::FRAC_BITS;
  localparam int LAST = gn2_pkg::NSTG - 1;

  gn2_pkg::stage_en_t en;
  gn2_pkg::stage_en_t vld;

  logic [gn2_pkg::XY_W-1:0] x_pos;
  logic [gn2_pkg::XY_W-1:0] y_pos;
  gn2_pkg::cell_t           x0;
  gn2_pkg::cell_t           y0;
  gn2_pkg::frac2_t          f_s0;
  gn2_pkg::frac2_t          f_s1;
  gn2_pkg::frac2_t          f_s2;
  gn2_pkg::frac2_t          f_s3;
  gn2_pkg::wgt2_t           s_s2;
  gn2_pkg::wgt2_t           s_s3;
  gn2_pkg::wgt2_t           s_s4;
  gn2_pkg::wgt2_t           s_s5;
  gn2_pkg::wgt2_t           s_s6;
  gn2_pkg::hash4_t          h_s3;
  gn2_pkg::dot4_t           n_s6;

  assign x_pos = s_axis_tdata[31:0];
  assign y_pos = s_axis_tdata[63:32];

  // A stage may load when it is empty or the stage after it loads too.
  always_comb begin
    en[LAST] = !vld[LAST] || m_axis_tready;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[LAST];

  // Valid flags move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < gn2_pkg::NSTG; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Input register: split each coordinate into cell and fraction.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0      <= x_pos[F +: gn2_pkg::INT_BITS];
      y0      <= y_pos[F +: gn2_pkg::INT_BITS];
      f_s0[0] <= x_pos[F-1:0];
      f_s0[1] <= y_pos[F-1:0];
    end
  end

  // Fractions wait for the hash; weights wait for the dot products.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      f_s1 <= f_s0;
    end
    if (en[2]) begin
      f_s2 <= f_s1;
    end
    if (en[3]) begin
      f_s3 <= f_s2;
      s_s3 <= s_s2;
    end
    if (en[4]) begin
      s_s4 <= s_s3;
    end
    if (en[5]) begin
      s_s5 <= s_s4;
    end
    if (en[6]) begin
      s_s6 <= s_s5;
    end
  end

  gn2_hash u_hash (
    .clk (clk),
    .en  (en),
    .x0  (x0),
    .y0  (y0),
    .h   (h_s3)
  );

  gn2_weight u_weight (
    .clk (clk),
    .en  (en),
    .f   (f_s0),
    .s   (s_s2)
  );

  gn2_grad u_grad (
    .clk (clk),
    .en  (en),
    .h   (h_s3),
    .fx  (f_s3[0]),
    .fy  (f_s3[1]),
    .n   (n_s6)
  );

  gn2_blend u_blend (
    .clk         (clk),
    .en          (en),
    .n           (n_s6),
    .sx          (s_s6[0]),
    .sy          (s_s6[1]),
    .noise_value (m_axis_tdata)
  );

  // An open output lets every stage move, so the input side is ready.
  `GN2_ASSERT_SAME(a_ready_flow, m_axis_tready, s_axis_tready)
  // An accepted beat occupies the input register on the next cycle.
  `GN2_ASSERT_NEXT(a_in_capture, s_axis_tvalid && s_axis_tready, vld[0])
  // A new result can only come from a full stage ahead of the output.
  `GN2_ASSERT_SAME(a_out_source, $rose(m_axis_tvalid), $past(vld[LAST-1]))

endmodule

[rtl/gn2_hash.sv]
// ----------------------------------------------------------------------------
// Gradient noise corner hash
// Three-stage multiply-xor-rotate hash of the four cell corners, one
// multiplier rank per stage (pipeline stages 1 to 3).
// ----------------------------------------------------------------------------
module gn2_hash (
  input  logic              clk,
  input  gn2_pkg::stage_en_t en,
  input  gn2_pkg::cell_t    x0,
  input  gn2_pkg::cell_t    y0,
  output gn2_pkg::hash4_t   h
);

  logic [1:0][gn2_pkg::XY_W-1:0] ax;
  logic [1:0][gn2_pkg::XY_W-1:0] ax_next;
  logic [1:0][gn2_pkg::XY_W-1:0] ax_s2;
  gn2_pkg::cell_t                y0_s1;
  gn2_pkg::hash4_t               b;
  gn2_pkg::hash4_t               b_next;
  gn2_pkg::hash4_t               h_next;

  // Stage 1: first multiply on the left and right column coordinates.
  always_comb begin
    logic [gn2_pkg::XY_W-1:0] cx;
    for (int i = 0; i < 2; i++) begin
      cx = gn2_pkg::XY_W'(x0) + gn2_pkg::XY_W'(i);
      ax_next[i] = cx * gn2_pkg::HASH_K1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ax    <= ax_next;
      y0_s1 <= y0;
    end
  end

  // Stage 2: mix in the row coordinate and multiply.
  always_comb begin
    logic [gn2_pkg::XY_W-1:0] cy;
    for (int c = 0; c < 4; c++) begin
      cy = gn2_pkg::XY_W'(y0_s1) + gn2_pkg::XY_W'(c[1]);
      b_next[c] = (cy ^ gn2_pkg::rot16(ax[c[0]])) * gn2_pkg::HASH_K2;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      b     <= b_next;
      ax_s2 <= ax;
    end
  end

  // Stage 3: fold back into the column word and multiply.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      h_next[c] = (ax_s2[c[0]] ^ gn2_pkg::rot16(b[c])) * gn2_pkg::HASH_K3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      h <= h_next;
    end
  end

endmodule

[rtl/gn2_weight.sv]
// ----------------------------------------------------------------------------
// Gradient noise smoothstep weights
// Computes 3w^2-2w^3 for the x and y fractions over two stages
// (pipeline stages 1 and 2).
// ----------------------------------------------------------------------------
module gn2_weight (
  input  logic              clk,
  input  gn2_pkg::stage_en_t en,
  input  gn2_pkg::frac2_t   f,
  output gn2_pkg::wgt2_t    s
);

  localparam int F = gn2_pkg::FRAC_BITS;

  gn2_pkg::frac2_t sq;
  gn2_pkg::frac2_t sq_next;
  gn2_pkg::frac2_t f_s1;
  gn2_pkg::wgt2_t  s_next;

  // Stage 1: square of the fraction, back in Q.F.
  always_comb begin
    logic [2*F-1:0] fsq;
    for (int i = 0; i < 2; i++) begin
      fsq        = (2*F)'(f[i]) * (2*F)'(f[i]);
      sq_next[i] = fsq[F +: F];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sq   <= sq_next;
      f_s1 <= f;
    end
  end

  // Stage 2: multiply by (3 - 2w), giving a weight in 0..1 inclusive.
  always_comb begin
    logic [F+1:0]   tw;
    logic [2*F+1:0] prod;
    for (int i = 0; i < 2; i++) begin
      tw        = (F+2)'(3 << F) - (F+2)'({f_s1[i], 1'b0});
      prod      = (2*F+2)'(sq[i]) * (2*F+2)'(tw);
      s_next[i] = prod[F +: F+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s <= s_next;
    end
  end

endmodule

[rtl/gn2_grad.sv]
// ----------------------------------------------------------------------------
// Gradient noise corner dot products
// Looks up each corner's unit gradient, multiplies it with the corner offset
// and rounds the sum to Q2.14 (pipeline stages 4 to 6).
// ----------------------------------------------------------------------------
module gn2_grad (
  input  logic              clk,
  input  gn2_pkg::stage_en_t en,
  input  gn2_pkg::hash4_t   h,
  input  gn2_pkg::frac_t    fx,
  input  gn2_pkg::frac_t    fy,
  output gn2_pkg::dot4_t    n
);

  localparam int F  = gn2_pkg::FRAC_BITS;
  localparam int AB = gn2_pkg::ANGLE_BITS;
  localparam int PW = F + 1 + gn2_pkg::GW;
  localparam logic signed [PW:0] RND = (PW+1)'(gn2_pkg::ROUND_HALF);

  gn2_pkg::grad_t              gx [4];
  gn2_pkg::grad_t              gy [4];
  gn2_pkg::grad_t              gx_next [4];
  gn2_pkg::grad_t              gy_next [4];
  gn2_pkg::frac_t              fx_s4;
  gn2_pkg::frac_t              fy_s4;
  logic signed [PW-1:0]        px [4];
  logic signed [PW-1:0]        py [4];
  logic signed [PW-1:0]        px_next [4];
  logic signed [PW-1:0]        py_next [4];
  gn2_pkg::dot4_t              n_next;

  // Stage 4: gradient table lookup, sine for x and cosine for y.
  always_comb begin
    logic [AB-1:0] k;
    for (int c = 0; c < 4; c++) begin
      k          = h[c][gn2_pkg::XY_W-1 -: AB];
      gx_next[c] = gn2_pkg::grad_lut(k);
      gy_next[c] = gn2_pkg::grad_lut(k + AB'(gn2_pkg::QSZ));
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      gx    <= gx_next;
      gy    <= gy_next;
      fx_s4 <= fx;
      fy_s4 <= fy;
    end
  end

  // Stage 5: offset times gradient; a far corner's offset is the fraction
  // minus one, which is the fraction with the sign bit set.
  always_comb begin
    logic signed [F:0] dxv;
    logic signed [F:0] dyv;
    for (int c = 0; c < 4; c++) begin
      dxv        = $signed({c[0], fx_s4});
      dyv        = $signed({c[1], fy_s4});
      px_next[c] = dxv * gx[c];
      py_next[c] = dyv * gy[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      px <= px_next;
      py <= py_next;
    end
  end

  // Stage 6: add, round to nearest and drop the offset fraction bits.
  always_comb begin
    logic signed [PW:0] sum;
    for (int c = 0; c < 4; c++) begin
      sum       = (PW+1)'(px[c]) + (PW+1)'(py[c]) + RND;
      n_next[c] = sum[F +: gn2_pkg::NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      n <= n_next;
    end
  end

endmodule

[rtl/gn2_blend.sv]
// ----------------------------------------------------------------------------
// Gradient noise interpolation
// Blends the four corner values along x and then along y with the smoothstep
// weights, and saturates to Q2.14 (pipeline stages 7 to 10).
// ----------------------------------------------------------------------------
module gn2_blend (
  input  logic                       clk,
  input  gn2_pkg::stage_en_t          en,
  input  gn2_pkg::dot4_t             n,
  input  gn2_pkg::wgt_t              sx,
  input  gn2_pkg::wgt_t              sy,
  output logic [gn2_pkg::OUT_W-1:0]  noise_value
);

  localparam int F  = gn2_pkg::FRAC_BITS;
  localparam int NW = gn2_pkg::NW;
  localparam int BW = NW + 1 + F + 2;
  localparam logic signed [BW-1:0] RND  = BW'(gn2_pkg::ROUND_HALF);
  localparam logic signed [NW:0]   VMAX = (NW+1)'((1 << (gn2_pkg::OUT_W - 1)) - 1);
  localparam logic signed [NW:0]   VMIN = -VMAX - (NW+1)'(1);

  logic signed [BW-1:0] pr [2];
  logic signed [BW-1:0] pr_next [2];
  logic signed [NW-1:0] base_s7 [2];
  gn2_pkg::wgt_t        sy_s7;
  gn2_pkg::wgt_t        sy_s8;
  logic signed [NW-1:0] row [2];
  logic signed [NW-1:0] row_next [2];
  logic signed [BW-1:0] py;
  logic signed [BW-1:0] py_next;
  logic signed [NW-1:0] row0_s9;
  logic [gn2_pkg::OUT_W-1:0] noise_next;

  // Stage 7: corner differences along x times the x weight.
  always_comb begin
    logic signed [NW:0]  d;
    logic signed [F+1:0] w;
    w = $signed({1'b0, sx});
    for (int r = 0; r < 2; r++) begin
      d          = (NW+1)'($signed(n[2*r+1])) - (NW+1)'($signed(n[2*r]));
      pr_next[r] = d * w;
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      pr         <= pr_next;
      base_s7[0] <= $signed(n[0]);
      base_s7[1] <= $signed(n[2]);
      sy_s7      <= sy;
    end
  end

  // Stage 8: round the step and add it to the left corner of each row.
  always_comb begin
    logic signed [BW-1:0] t;
    logic signed [NW:0]   v;
    for (int r = 0; r < 2; r++) begin
      t           = pr[r] + RND;
      v           = (NW+1)'(base_s7[r]) + $signed(t[F +: NW+1]);
      row_next[r] = v[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      row   <= row_next;
      sy_s8 <= sy_s7;
    end
  end

  // Stage 9: row difference along y times the y weight.
  always_comb begin
    logic signed [NW:0]  d;
    logic signed [F+1:0] w;
    w       = $signed({1'b0, sy_s8});
    d       = (NW+1)'(row[1]) - (NW+1)'(row[0]);
    py_next = d * w;
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      py      <= py_next;
      row0_s9 <= row[0];
    end
  end

  // Stage 10: final rounding step and saturation into the output register.
  always_comb begin
    logic signed [BW-1:0] t;
    logic signed [NW:0]   v;
    t = py + RND;
    v = (NW+1)'(row0_s9) + $signed(t[F +: NW+1]);
    if (v > VMAX) begin
      noise_next = VMAX[gn2_pkg::OUT_W-1:0];
    end else if (v < VMIN) begin
      noise_next = VMIN[gn2_pkg::OUT_W-1:0];
    end else begin
      noise_next = v[gn2_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      noise_value <= noise_next;
    end
  end

endmodule

[bench/gradient_noise_2d_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gradient noise testbench
// Streams points into the noise block and checks every returned sample
// against a bit-accurate predictor of the hashed-gradient noise. Both
// stream sides idle at random, and the output side holds off once for a
// long stretch so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module gradient_noise_2d_top_tb;

  localparam int   ANGLE_BITS = gn2_pkg::ANGLE_BITS;
  localparam int   FRAC_BITS  = gn2_pkg::FRAC_BITS;
  localparam int   INT_BITS   = gn2_pkg::INT_BITS;
  localparam int   OUT_W      = gn2_pkg::OUT_W;
  localparam int   NUM_RANDOM = 1600;
  localparam int   TAIL_WAIT  = 4 * gn2_pkg::NSTG;
  localparam int   QUARTER    = 1 << (ANGLE_BITS - 2);
  localparam int   FULL_TURN  = 1 << ANGLE_BITS;
  localparam longint ONE_Q    = 64'sd1 <<< FRAC_BITS;
  localparam longint HALF_Q   = 64'sd1 <<< (FRAC_BITS - 1);

  // Predicts noise samples and holds them in arrival order until the block
  // returns them.
  class noise_scoreboard;
    logic signed [OUT_W-1:0] expected_noise[$];
    longint                  sine_q14[QUARTER+1];
    int                      errors;
    int                      checked;

    function new();
      longint unsigned theta;
      longint unsigned t2;
      longint unsigned term;
      longint          sum;
      errors  = 0;
      checked = 0;
      // Quarter-wave sine in Q14 from a truncated Taylor series in Q30.
      for (int r = 0; r <= QUARTER; r++) begin
        theta = (64'(r) * gn2_pkg::TWO_PI_Q30) >> ANGLE_BITS;
        t2    = (theta * theta) >> 30;
        term  = theta;
        sum   = longint'(theta);
        for (int k = 1; k <= 7; k++) begin
          term = ((term * t2) >> 30) / longint'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        sine_q14[r] = (sum + 32768) >>> 16;
      end
    endfunction

    // Multiply-xor-rotate hash of one corner.
    function logic [31:0] corner_angle_word(logic [31:0] cx, logic [31:0] cy);
      logic [31:0] a;
      logic [31:0] b;
      a = cx * gn2_pkg::HASH_K1;
      b = cy ^ {a[15:0], a[31:16]};
      b = b * gn2_pkg::HASH_K2;
      a = a ^ {b[15:0], b[31:16]};
      a = a * gn2_pkg::HASH_K3;
      return a;
    endfunction

    // Signed Q14 sine of table angle k, by quarter-wave symmetry.
    function longint table_sine(int k);
      int     quad;
      int     r;
      longint m;
      k    = k % FULL_TURN;
      quad = k / QUARTER;
      r    = k % QUARTER;
      if (quad % 2 == 1) begin
        r = QUARTER - r;
      end
      m = sine_q14[r];
      return (quad >= 2) ? -m : m;
    endfunction

    // Gradient of the corner dotted with the offset, rounded to Q14.
    function longint corner_dot(logic [31:0] cx, logic [31:0] cy,
                                longint dx, longint dy);
      logic [31:0] h;
      int          k;
      longint      prod;
      h    = corner_angle_word(cx, cy);
      k    = int'(h >> (32 - ANGLE_BITS));
      prod = dx * table_sine(k) + dy * table_sine(k + QUARTER);
      return (prod + HALF_Q) >>> FRAC_BITS;
    endfunction

    // Smoothstep weight 3f^2 - 2f^3 in Q.FRAC_BITS.
    function longint fade_weight(longint f);
      longint sq;
      sq = (f * f) >>> FRAC_BITS;
      return (sq * (3 * ONE_Q - 2 * f)) >>> FRAC_BITS;
    endfunction

    function longint lerp_q(longint p, longint q, longint s);
      return p + (((q - p) * s + HALF_Q) >>> FRAC_BITS);
    endfunction

    function logic signed [OUT_W-1:0] predict_noise(logic [31:0] x, logic [31:0] y);
      longint      fx;
      longint      fy;
      logic [31:0] x0;
      logic [31:0] y0;
      longint      sx;
      longint      sy;
      longint      row0;
      longint      row1;
      longint      v;
      fx   = longint'(x[FRAC_BITS-1:0]);
      fy   = longint'(y[FRAC_BITS-1:0]);
      x0   = 32'(x[FRAC_BITS +: INT_BITS]);
      y0   = 32'(y[FRAC_BITS +: INT_BITS]);
      sx   = fade_weight(fx);
      sy   = fade_weight(fy);
      // Blend along x on both rows, then along y.
      row0 = lerp_q(corner_dot(x0, y0, fx, fy),
                    corner_dot(x0 + 1, y0, fx - ONE_Q, fy), sx);
      row1 = lerp_q(corner_dot(x0, y0 + 1, fx, fy - ONE_Q),
                    corner_dot(x0 + 1, y0 + 1, fx - ONE_Q, fy - ONE_Q), sx);
      v    = lerp_q(row0, row1, sy);
      if (v > 32767) begin
        v = 32767;
      end
      if (v < -32768) begin
        v = -32768;
      end
      return OUT_W'(v);
    endfunction

    function void note_point(logic [31:0] x, logic [31:0] y);
      expected_noise.push_back(predict_noise(x, y));
    endfunction

    task report_mismatch(string what);
      $display("%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_noise(logic signed [OUT_W-1:0] got);
      logic signed [OUT_W-1:0] want;
      checked++;
      if (expected_noise.size() == 0) begin
        report_mismatch($sformatf("noise beat %0d with no point waiting", got));
      end else begin
        want = expected_noise.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("noise_value got %0d expected %0d", got, want));
        end
      end
    endtask

    function int pending();
      return expected_noise.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [31:0] x_pos, [63:32] y_pos
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [15:0] noise_value

  noise_scoreboard noise_sb;
  int              points_sent;
  bit              hold_done;

  gradient_noise_2d_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Record accepted points and check accepted noise beats.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      noise_sb.note_point(s_axis_tdata[31:0], s_axis_tdata[63:32]);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      noise_sb.check_noise(m_axis_tdata);
    end
  end

  // Offer one point, with a random gap except in the steady stretch.
  task automatic send_point(input logic [31:0] x, input logic [31:0] y);
    bit steady;
    steady = (points_sent >= 500 && points_sent < 900);
    while (!steady && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    points_sent++;
  endtask

  // Random pick among the fraction extremes and one half.
  function automatic logic [15:0] edge_fraction();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'hFFFF;
      default: return 16'h8000;
    endcase
  endfunction

  // Output side: random stalls, a steady stretch, and one long hold-off.
  initial begin
    int hold_left;
    hold_left     = 0;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && noise_sb.checked >= 1000) begin
        hold_done = 1'b1;
        hold_left = 80;
        m_axis_tready <= 1'b0;
      end else if (noise_sb.checked >= 200 && noise_sb.checked < 500) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 8);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [31:0] walk_x;
    logic [31:0] walk_y;
    logic [31:0] x;
    logic [31:0] y;
    int          mode;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    points_sent   = 0;
    noise_sb      = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed points: field extremes, grid points, the last cell whose
    // right neighbor is not wrapped, and half-way fractions.
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'h0000_FFFF, 32'h0000_FFFF);
    send_point(32'hFFFF_0000, 32'hFFFF_0000);
    send_point(32'h0001_8000, 32'h0002_8000);
    send_point(32'hFFFF_8000, 32'h0000_4000);
    send_point(32'h0000_8000, 32'hFFFF_FFFF);
    send_point(32'h1234_0001, 32'h5678_FFFE);
    send_point(32'h0000_0001, 32'h0000_0001);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'hAAAA_AAAA, 32'h5555_5555);
    send_point(32'h5555_5555, 32'hAAAA_AAAA);
    send_point(32'h0000_C000, 32'h0000_0000);
    send_point(32'h0000_0000, 32'h0000_C000);
    send_point(32'h0010_0000, 32'h0010_0000);
    send_point(32'hFFFF_FFFF, 32'h0000_0000);
    send_point(32'h0000_0000, 32'hFFFF_FFFF);

    // Random points: uniform, fraction extremes, and short walks that
    // cross neighboring cells.
    walk_x = $urandom;
    walk_y = $urandom;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      mode = $urandom_range(9);
      if (mode == 0) begin
        x = {16'($urandom), edge_fraction()};
        y = {16'($urandom), edge_fraction()};
      end else if (mode <= 2) begin
        walk_x = walk_x + $urandom_range(32'h0000_4000);
        walk_y = walk_y + $urandom_range(32'h0000_2000);
        x      = walk_x;
        y      = walk_y;
      end else begin
        x = $urandom;
        y = $urandom;
      end
      send_point(x, y);
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);

    while (noise_sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_WAIT) @(posedge clk);
    if (noise_sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
